// ===== design/ccm_pkg.sv =====
// ----------------------------------------------------------------------------
// ccm_pkg: shared types and constants of the color matrix block
// Holds the coefficient and matrix types, register indexes, selector codes
// and the fixed target matrices in unsigned Q.18.
// ----------------------------------------------------------------------------
package ccm_pkg;

	// fraction bits of the combined matrix
	localparam int MAT_FRAC = 18;
	localparam int MAT_W    = 24;

	typedef logic signed [15:0]      coef_t;
	typedef logic signed [MAT_W-1:0] ment_t;
	typedef logic [2:0][15:0]        cam_row_t;   // column c in [c]
	typedef ment_t [8:0]             mat_t;       // row major

	// matrix and recompute status handed to the pixel datapath
	typedef struct packed {
		logic busy;
		mat_t mat;
	} mat_status_t;

	localparam ment_t MAT_ONE = ment_t'(1 << MAT_FRAC);
	localparam logic signed [37:0] MAT_MAX = 38'sd8388607;
	localparam logic signed [37:0] MAT_MIN = -38'sd8388608;

	// camera coefficient 1.0 in Q3.12
	localparam logic [15:0] CAM_ONE = 16'd4096;

	// register indexes
	localparam logic [2:0] REG_CAM_ROW0    = 3'd0;
	localparam logic [2:0] REG_CAM_ROW1    = 3'd1;
	localparam logic [2:0] REG_CAM_ROW2    = 3'd2;
	localparam logic [2:0] REG_COLOR_SPACE = 3'd3;

	// color space selector codes
	localparam logic [2:0] CS_BYPASS   = 3'd0;
	localparam logic [2:0] CS_IDENTITY = 3'd1;
	localparam logic [2:0] CS_XYZ      = 3'd5;

	// target matrices: identity, Adobe, wide gamut, ProPhoto, XYZ
	localparam logic [18:0] TARGET_TAB [5][3][3] = '{
		'{'{19'd262144, 19'd0,      19'd0},
		  '{19'd0,      19'd262144, 19'd0},
		  '{19'd0,      19'd0,      19'd262144}},
		'{'{19'd187471, 19'd74673,  19'd0},
		  '{19'd0,      19'd262144, 19'd0},
		  '{19'd0,      19'd10791,  19'd251354}},
		'{'{19'd155474, 19'd106092, 19'd578},
		  '{19'd25012,  19'd221026, 19'd16106},
		  '{19'd3046,   19'd18112,  19'd240986}},
		'{'{19'd138757, 19'd86532,  19'd36854},
		  '{19'd25787,  19'd228974, 19'd7384},
		  '{19'd4425,   19'd30845,  19'd226874}},
		'{'{19'd108122, 19'd93737,  19'd47297},
		  '{19'd55750,  19'd187475, 19'd18919},
		  '{19'd5068,   19'd31246,  19'd249096}}
	};

endpackage

// ===== design/camera_rgb_color_matrix_top.sv =====
// ----------------------------------------------------------------------------
// camera_rgb_color_matrix_top: 3x3 color correction of an RGB pixel stream
// Pixels enter on the s_axis channel (red, green, blue in tdata, last pixel
// of the image in tlast) and leave on m_axis in the same packing, converted
// by the combined target * camera matrix and clamped to the sample range.
// Registers are written through cfg_we / cfg_addr / cfg_wdata: index 0..2
// camera matrix rows, index 3 color space selector. Write only while idle.
// Each write to index 0..3 rebuilds the combined matrix one entry a cycle, so
// s_axis_tready stays low until the rebuild ends; reset loads identity at once.
// A pixel passes through the input, product and output registers in turn.
// Throughput is one pixel per clock while no rebuild runs and m_axis_tready
// is high, set by the nine parallel product lanes. When it is low the stages
// fill and s_axis_tready drops once all three hold a pixel; nothing is lost.
// Reset clears all stage valids and loads the register reset values.
// ----------------------------------------------------------------------------
module camera_rgb_color_matrix_top import ccm_pkg::*; #(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [47:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // red_in, green_in, blue_in
	input  logic        s_axis_tlast,   // frame_last_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // red_out, green_out, blue_out
	output logic        m_axis_tlast    // frame_last_out
);

	mat_status_t status;

	// configuration and combined matrix
	ccm_matrix_calc #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.status   (status)
	);

	// pixel datapath
	ccm_pixel_pipe #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.status       (status),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

// ===== design/ccm_matrix_calc.sv =====
// ----------------------------------------------------------------------------
// ccm_matrix_calc: configuration registers and combined matrix sequencer
// Holds the camera matrix and selector, and after each write to index 0..3
// forms all nine entries of target * camera (or identity) one per cycle.
// ----------------------------------------------------------------------------
module ccm_matrix_calc import ccm_pkg::*; #(
	parameter int COEF_FRAC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [47:0] cfg_wdata,
	output mat_status_t status
);

	cam_row_t   cam_q [3];
	logic [2:0] cs_q;
	mat_t       mat_q;
	logic       busy_q;
	logic [3:0] idx_q;
	logic [1:0] row_q;
	logic [1:0] col_q;

	logic               cs_valid;
	logic [2:0]         tsel;
	logic [18:0]        t [3];
	coef_t              c [3];
	logic signed [35:0] p [3];
	logic signed [37:0] acc;
	logic signed [37:0] shifted;
	ment_t              ent;

	// entry (row, col): target row dot camera column, else identity (bypass)
	always_comb begin
		cs_valid = (cs_q >= CS_IDENTITY) && (cs_q <= CS_XYZ);
		tsel     = cs_valid ? (cs_q - CS_IDENTITY) : 3'd0;
		for (int k = 0; k < 3; k++) begin
			t[k] = TARGET_TAB[tsel][row_q][k];
			c[k] = coef_t'(cam_q[k][col_q]);
			p[k] = $signed({1'b0, t[k]}) * c[k];
		end
		acc     = 38'(p[0]) + 38'(p[1]) + 38'(p[2]);
		shifted = acc >>> COEF_FRAC_BITS;
		if (!cs_valid) begin
			ent = (row_q == col_q) ? MAT_ONE : '0;
		end else if (shifted > MAT_MAX) begin
			ent = ment_t'(MAT_MAX);
		end else if (shifted < MAT_MIN) begin
			ent = ment_t'(MAT_MIN);
		end else begin
			ent = shifted[MAT_W-1:0];
		end
	end

	// take register writes, restart the sweep, step one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= {16'd0, 16'd0, CAM_ONE};
			cam_q[1] <= {16'd0, CAM_ONE, 16'd0};
			cam_q[2] <= {CAM_ONE, 16'd0, 16'd0};
			cs_q     <= CS_BYPASS;
			for (int i = 0; i < 9; i++) begin
				mat_q[i] <= (i % 4 == 0) ? MAT_ONE : '0;
			end
			busy_q <= 1'b0;
			idx_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we && cfg_addr <= REG_COLOR_SPACE) begin
			unique case (cfg_addr)
				REG_CAM_ROW0, REG_CAM_ROW1, REG_CAM_ROW2: cam_q[cfg_addr[1:0]] <= cfg_wdata;
				default: cs_q <= cfg_wdata[2:0];
			endcase
			busy_q <= 1'b1;
			idx_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (busy_q) begin
			mat_q[idx_q] <= ent;
			idx_q        <= idx_q + 4'd1;
			if (col_q == 2'd2) begin
				col_q <= '0;
				row_q <= row_q + 2'd1;
			end else begin
				col_q <= col_q + 2'd1;
			end
			if (idx_q == 4'd8) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign status.busy = busy_q;
	assign status.mat  = mat_q;

	// sweep stays within the nine entries
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= 4'd8)
		else $error("matrix sweep index out of range");

	// a known register write always starts a sweep
	a_write_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_addr <= REG_COLOR_SPACE |=> busy_q && idx_q == 4'd0)
		else $error("register write did not restart the sweep");

	// row and column track the flat index
	a_row_col: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q == 4'(row_q) * 4'd3 + 4'(col_q))
		else $error("row and column out of step with index");

endmodule

// ===== design/ccm_pixel_pipe.sv =====
// ----------------------------------------------------------------------------
// ccm_pixel_pipe: three-stage pixel datapath
// Registers the input pixel, forms nine products, then sums, truncates and
// clamps each channel into the output register.
// ----------------------------------------------------------------------------
module ccm_pixel_pipe import ccm_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mat_status_t status,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // red, green, blue
	input  logic        s_axis_tlast,   // frame_last_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // red, green, blue
	output logic        m_axis_tlast    // frame_last_out
);

	localparam logic [15:0] SMASK = 16'((1 << SAMPLE_BITS) - 1);

	logic               v_s1, v_s2, v_s3;
	logic [15:0]        x_s1 [3];
	logic               last_s1, last_s2, last_s3;
	logic signed [40:0] p_s2 [3][3];
	logic [15:0]        y_s3 [3];

	logic               en1, en2, en3;
	logic               in_fire;
	logic signed [42:0] acc [3];
	logic [24:0]        q [3];
	logic [15:0]        y [3];

	// advance a stage when it is empty or its successor moves
	assign en3           = !v_s3 || m_axis_tready;
	assign en2           = !v_s2 || en3;
	assign en1           = !v_s1 || en2;
	assign s_axis_tready = en1 && !status.busy;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// sum, drop negatives, truncate and clamp
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = 43'(p_s2[i][0]) + 43'(p_s2[i][1]) + 43'(p_s2[i][2]);
			q[i]   = acc[i][MAT_FRAC +: 25];
			if (acc[i][42]) begin
				y[i] = '0;
			end else if (q[i] > 25'(SMASK)) begin
				y[i] = SMASK;
			end else begin
				y[i] = q[i][15:0];
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_fire;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en1 && in_fire) begin
			for (int c = 0; c < 3; c++) begin
				x_s1[c] <= s_axis_tdata[16*c +: 16] & SMASK;
			end
			last_s1 <= s_axis_tlast;
		end
		if (en2) begin
			for (int i = 0; i < 3; i++) begin
				for (int c = 0; c < 3; c++) begin
					p_s2[i][c] <= $signed(status.mat[i*3+c]) * $signed({1'b0, x_s1[c]});
				end
			end
			last_s2 <= last_s1;
		end
		if (en3) begin
			for (int i = 0; i < 3; i++) begin
				y_s3[i] <= y[i];
			end
			last_s3 <= last_s2;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {y_s3[2], y_s3[1], y_s3[0]};
	assign m_axis_tlast  = last_s3;

	// an accepted pixel lands in the first stage
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> v_s1)
		else $error("accepted pixel lost at input stage");

	// no pixel enters while the matrix is being rebuilt
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> !in_fire)
		else $error("pixel taken during matrix rebuild");

	// a full stalled stage keeps its item
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en3 |=> v_s2)
		else $error("middle stage dropped an item");

endmodule

// ===== bench/camera_rgb_color_matrix_top_tb.sv =====
// ----------------------------------------------------------------------------
// camera_rgb_color_matrix_top_tb: self-checking bench for the color matrix
// Streams RGB pixels through the block under a series of camera matrix and
// color space settings, with random gaps on the pixel input and random back
// pressure on the output. A local model rebuilds the combined matrix after
// every camera row or selector write, converts each accepted pixel, and the output side
// compares every transfer against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module camera_rgb_color_matrix_top_tb;
	import ccm_pkg::*;

	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_FRAC_BITS = 12;
	localparam int CYCLE_LIMIT    = 600000;
	localparam int RANDOM_PIXELS  = 1800;
	localparam int MAX_REPORTS    = 200;

	// selector codes not named in the package
	localparam logic [2:0] CS_ADOBE      = 3'd2;
	localparam logic [2:0] CS_WIDE_GAMUT = 3'd3;
	localparam logic [2:0] CS_PROPHOTO   = 3'd4;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [47:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // red_in, green_in, blue_in
	logic        s_axis_tlast = 1'b0; // frame_last_in
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // red_out, green_out, blue_out
	logic        m_axis_tlast;        // frame_last_out

	// model state: camera rows, selector and the combined matrix
	cam_row_t    cam_rows [3];
	logic [2:0]  cs_sel;
	mat_t        color_mat;

	pixel_t      pixel_pending_q [$];
	pixel_t      rgb_expect_q [$];

	int          err_cnt = 0;
	int          pix_in_cnt = 0;
	int          pix_out_cnt = 0;
	int          write_cnt = 0;
	int          setting_cnt = 0;
	int          cycle_cnt = 0;
	int          send_wait = 0;
	int          recv_wait = 0;
	bit          send_burst = 1'b0;
	bit          recv_burst = 1'b0;
	pixel_t      drv_px;
	pixel_t      mon_px;
	pixel_t      mon_exp;
	int          drv_gap;
	int          mon_gap;

	camera_rgb_color_matrix_top #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always #6 clk = ~clk;

	// rebuild target * camera in Q5.18, identity for bypass and unknown codes
	function automatic void rebuild_color_matrix();
		longint acc;
		longint tgt;
		longint coef;
		int     tsel;
		if (cs_sel < CS_IDENTITY || cs_sel > CS_XYZ) begin
			for (int e = 0; e < 9; e++)
				color_mat[e] = (e % 4 == 0) ? MAT_ONE : '0;
			return;
		end
		tsel = int'(cs_sel) - 1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) begin
					tgt  = longint'(TARGET_TAB[tsel][i][k]);
					coef = longint'(coef_t'(cam_rows[k][j]));
					acc += tgt * coef;
				end
				// arithmetic shift floors toward minus infinity
				acc = acc >>> COEF_FRAC_BITS;
				if (acc > 64'sd8388607)
					acc = 64'sd8388607;
				if (acc < -64'sd8388608)
					acc = -64'sd8388608;
				color_mat[i*3+j] = ment_t'(acc);
			end
		end
	endfunction

	// multiply one pixel by the combined matrix, truncate and clamp
	function automatic pixel_t convert_pixel(input pixel_t px);
		longint      acc;
		longint      x [3];
		logic [15:0] ch [3];
		pixel_t      res;
		x[0] = longint'(px.red);
		x[1] = longint'(px.green);
		x[2] = longint'(px.blue);
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int c = 0; c < 3; c++)
				acc += longint'(color_mat[i*3+c]) * x[c];
			if (acc < 0)
				ch[i] = '0;
			else begin
				acc = acc >>> MAT_FRAC;
				ch[i] = (acc > 64'sd65535) ? 16'hFFFF : acc[15:0];
			end
		end
		res.red   = ch[0];
		res.green = ch[1];
		res.blue  = ch[2];
		res.last  = px.last;
		return res;
	endfunction

	function automatic logic [47:0] pack_row(input int c0, input int c1, input int c2);
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		a = c0[15:0];
		b = c1[15:0];
		c = c2[15:0];
		return {c, b, a};
	endfunction

	function automatic logic [47:0] random_word48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[47:0];
	endfunction

	// plausible camera row: strong diagonal, small signed off-diagonal terms
	function automatic logic [47:0] plausible_row(input int r);
		int c [3];
		for (int k = 0; k < 3; k++) begin
			if (k == r)
				c[k] = 4096 + int'($urandom_range(0, 3072)) - 1024;
			else
				c[k] = int'($urandom_range(0, 2000)) - 1500;
		end
		return pack_row(c[0], c[1], c[2]);
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		logic [15:0] ch [3];
		int kind;
		kind = $urandom_range(0, 7);
		for (int c = 0; c < 3; c++) begin
			case (kind)
				0: ch[c] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				1: ch[c] = 16'($urandom_range(0, 255));
				2: ch[c] = 16'($urandom_range(16'hFF00, 16'hFFFF));
				default: ch[c] = 16'($urandom());
			endcase
		end
		px.red   = ch[0];
		px.green = ch[1];
		px.blue  = ch[2];
		px.last  = ($urandom_range(0, 15) == 0);
		return px;
	endfunction

	task automatic queue_pixel(input logic [15:0] r, input logic [15:0] g,
			input logic [15:0] b, input logic last);
		pixel_t px;
		px.red   = r;
		px.green = g;
		px.blue  = b;
		px.last  = last;
		pixel_pending_q.push_back(px);
	endtask

	// wait until every queued pixel has been sent and every result checked
	task automatic wait_drained();
		do @(negedge clk);
		while (pixel_pending_q.size() != 0 || s_axis_tvalid || rgb_expect_q.size() != 0);
		setting_cnt++;
	endtask

	// write one register, mirror it in the model and let the rebuild finish
	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		write_cnt++;
		case (idx)
			REG_CAM_ROW0, REG_CAM_ROW1, REG_CAM_ROW2: begin
				cam_rows[idx] = val;
				rebuild_color_matrix();
			end
			REG_COLOR_SPACE: begin
				cs_sel = val[2:0];
				rebuild_color_matrix();
			end
			default: ;
		endcase
		do @(negedge clk);
		while (!s_axis_tready);
	endtask

	task automatic write_all_rows(input logic [47:0] row);
		write_reg(REG_CAM_ROW0, row);
		write_reg(REG_CAM_ROW1, row);
		write_reg(REG_CAM_ROW2, row);
	endtask

	// pixel input driver: present queued pixels with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
			send_wait     <= 0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			// predict the pixel taken at this transfer
			drv_px.red   = s_axis_tdata[15:0];
			drv_px.green = s_axis_tdata[31:16];
			drv_px.blue  = s_axis_tdata[47:32];
			drv_px.last  = s_axis_tlast;
			rgb_expect_q.push_back(convert_pixel(drv_px));
			pix_in_cnt++;
			if ($urandom_range(0, 29) == 0)
				send_burst = !send_burst;
			drv_gap = send_burst ? 0 : $urandom_range(0, 19);
			if (drv_gap == 0 && pixel_pending_q.size() != 0) begin
				drv_px = pixel_pending_q.pop_front();
				s_axis_tdata <= {drv_px.blue, drv_px.green, drv_px.red};
				s_axis_tlast <= drv_px.last;
			end else begin
				s_axis_tvalid <= 1'b0;
				send_wait     <= (drv_gap > 0) ? drv_gap - 1 : 0;
			end
		end else if (!s_axis_tvalid) begin
			if (send_wait != 0)
				send_wait <= send_wait - 1;
			else if (pixel_pending_q.size() != 0) begin
				drv_px = pixel_pending_q.pop_front();
				s_axis_tdata  <= {drv_px.blue, drv_px.green, drv_px.red};
				s_axis_tlast  <= drv_px.last;
				s_axis_tvalid <= 1'b1;
			end
		end
	end

	// output monitor: random back pressure, check each transfer in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_wait     <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			mon_px.red   = m_axis_tdata[15:0];
			mon_px.green = m_axis_tdata[31:16];
			mon_px.blue  = m_axis_tdata[47:32];
			mon_px.last  = m_axis_tlast;
			pix_out_cnt++;
			if (rgb_expect_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t: unexpected pixel r=%h g=%h b=%h last=%b", $time,
						mon_px.red, mon_px.green, mon_px.blue, mon_px.last);
			end else begin
				mon_exp = rgb_expect_q.pop_front();
				if (mon_px.red !== mon_exp.red || mon_px.green !== mon_exp.green ||
						mon_px.blue !== mon_exp.blue || mon_px.last !== mon_exp.last) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: pixel %0d expected r=%h g=%h b=%h last=%b, got r=%h g=%h b=%h last=%b",
							$time, pix_out_cnt, mon_exp.red, mon_exp.green, mon_exp.blue,
							mon_exp.last, mon_px.red, mon_px.green, mon_px.blue, mon_px.last);
				end
			end
			if ($urandom_range(0, 29) == 0)
				recv_burst = !recv_burst;
			mon_gap = recv_burst ? 0 : $urandom_range(0, 19);
			if (mon_gap != 0) begin
				m_axis_tready <= 1'b0;
				recv_wait     <= mon_gap - 1;
			end
		end else if (!m_axis_tready) begin
			if (recv_wait != 0)
				recv_wait <= recv_wait - 1;
			else
				m_axis_tready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d pixels still expected", $time, rgb_expect_q.size());
			$display("camera_rgb_color_matrix_top test failed");
			$finish;
		end
	end

	initial begin
		int          rand_sent;
		int          n_pix;
		bit          wrote;
		logic [47:0] val;
		logic [47:0] row_val;

		// model reset state: identity camera matrix, bypass
		cam_rows[0] = 48'(CAM_ONE);
		cam_rows[1] = 48'(CAM_ONE) << 16;
		cam_rows[2] = 48'(CAM_ONE) << 32;
		cs_sel      = CS_BYPASS;
		rebuild_color_matrix();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// bypass after reset: field extremes and alternating bits
		queue_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
		queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		queue_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
		queue_pixel(16'h5555, 16'hAAAA, 16'h5555, 1'b1);
		queue_pixel(16'h0001, 16'h8000, 16'h7FFF, 1'b0);
		wait_drained();

		// identity target on the reset camera matrix
		write_reg(REG_COLOR_SPACE, 48'(CS_IDENTITY));
		queue_pixel(16'hFFFF, 16'h0000, 16'h1234, 1'b0);
		queue_pixel(16'h8000, 16'h8000, 16'h8000, 1'b1);
		wait_drained();

		// largest coefficients: a full-scale pixel clamps high
		write_all_rows(pack_row(32767, 32767, 32767));
		write_reg(REG_COLOR_SPACE, 48'(CS_XYZ));
		queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		queue_pixel(16'h0001, 16'h0001, 16'h0001, 1'b0);
		queue_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
		wait_drained();

		// most negative coefficients: outputs clamp to zero
		write_all_rows(pack_row(-32768, -32768, -32768));
		write_reg(REG_COLOR_SPACE, 48'(CS_PROPHOTO));
		queue_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		queue_pixel(16'h0000, 16'h0000, 16'h0000, 1'b1);
		wait_drained();

		// a realistic camera matrix under Adobe, then wide gamut
		write_reg(REG_CAM_ROW0, pack_row(6000, -1500, -400));
		write_reg(REG_CAM_ROW1, pack_row(-900, 5200, -200));
		write_reg(REG_CAM_ROW2, pack_row(100, -1300, 5300));
		write_reg(REG_COLOR_SPACE, 48'(CS_ADOBE));
		queue_pixel(16'h8000, 16'h4000, 16'h2000, 1'b0);
		queue_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
		wait_drained();
		write_reg(REG_COLOR_SPACE, 48'(CS_WIDE_GAMUT));
		queue_pixel(16'h1234, 16'hABCD, 16'h0F0F, 1'b0);
		queue_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
		wait_drained();

		// writes to unused indexes must leave the matrix alone
		for (int a = int'(REG_COLOR_SPACE) + 1; a < 8; a++)
			write_reg(3'(a), random_word48());
		queue_pixel(16'h7FFF, 16'h8000, 16'hC000, 1'b0);
		queue_pixel(16'h00FF, 16'hFF00, 16'hF0F0, 1'b1);
		wait_drained();

		// unknown selector codes act as bypass, upper data bits ignored
		write_reg(REG_COLOR_SPACE, 48'(CS_XYZ + 3'd1));
		queue_pixel(16'h1357, 16'h2468, 16'hFFFF, 1'b0);
		queue_pixel(16'hFFFF, 16'h0000, 16'h8001, 1'b1);
		wait_drained();
		write_reg(REG_COLOR_SPACE, {45'(random_word48() >> 3), 3'(CS_XYZ + 3'd2)});
		queue_pixel(16'hFEDC, 16'h0123, 16'h4567, 1'b0);
		queue_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
		wait_drained();

		// zero camera matrix
		write_all_rows(48'h0);
		write_reg(REG_COLOR_SPACE, 48'(CS_IDENTITY));
		queue_pixel(16'hFFFF, 16'h8000, 16'h0001, 1'b1);
		wait_drained();

		// random settings, each followed by a burst of random pixels
		rand_sent = 0;
		while (rand_sent < RANDOM_PIXELS) begin
			wrote = 1'b0;
			for (int r = 0; r < 3; r++) begin
				if ($urandom_range(0, 1) == 1) begin
					case ($urandom_range(0, 15))
						0, 1:    row_val = random_word48();
						2:       row_val = pack_row(32767, 32767, 32767);
						3:       row_val = pack_row(-32768, -32768, -32768);
						4:       row_val = 48'h0;
						default: row_val = plausible_row(r);
					endcase
					write_reg(3'(r), row_val);
					wrote = 1'b1;
				end
			end
			if (!wrote || $urandom_range(0, 1) == 1) begin
				val = 48'($urandom_range(0, 7));
				if ($urandom_range(0, 3) == 0)
					val[47:3] = 45'(random_word48() >> 3);
				write_reg(REG_COLOR_SPACE, val);
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(3'($urandom_range(int'(REG_COLOR_SPACE) + 1, 7)), random_word48());
			n_pix = $urandom_range(10, 120);
			for (int p = 0; p < n_pix; p++)
				pixel_pending_q.push_back(random_pixel());
			rand_sent += n_pix;
			wait_drained();
		end

		// let any stray output show up
		repeat (20) @(posedge clk);
		if (rgb_expect_q.size() != 0) begin
			err_cnt++;
			$display("%0t: %0d expected pixels never arrived", $time, rgb_expect_q.size());
		end
		$display("Sent %0d pixels, checked %0d results over %0d matrix settings",
			pix_in_cnt, pix_out_cnt, setting_cnt);
		$display("Issued %0d register writes, unused indexes and selector codes included",
			write_cnt);
		if (err_cnt == 0)
			$display("camera_rgb_color_matrix_top test passed");
		else
			$display("camera_rgb_color_matrix_top test failed");
		$finish;
	end

endmodule
